/* hdl/rgv_pkg.sv */
// shared types and constants for the voxel traversal block
`default_nettype none

package rgv_pkg;

    localparam int MAX_CELLS  = 16;
    localparam int COORD_FRAC = 16;
    localparam int T_W        = 48;
    localparam int T_FRAC     = 24;
    localparam int TS_W       = T_W + 1;

    localparam logic signed [T_W-1:0] T_MAXV = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_MINV = {1'b1, {(T_W-1){1'b0}}};

    // widths of the datapath values
    localparam int NUM_W  = 40;
    localparam int DVD_W  = NUM_W + T_FRAC;
    localparam int DVS_W  = 32;
    localparam int MX_W   = 38;
    localparam int PROD_W = 56;
    localparam int SM_W   = 42;
    localparam int DF_W   = 44;
    localparam int LIM_W  = 41;

    localparam logic [LIM_W-1:0] PROD_LIMIT = {1'b1, {(LIM_W-1){1'b0}}};

    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef struct packed {
        logic [2:0][31:0] gmin;
        logic [30:0]      size;
        logic [2:0][4:0]  cells;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SLAB, ST_T1W, ST_T2W, ST_HITCHK, ST_MISS, ST_MHI, ST_MLO,
        ST_MSUM, ST_DIFF, ST_CDIV, ST_CELLW, ST_AXIS, ST_INCW, ST_NEXTW, ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SLAB_ZERO, OP_T1_SAVE, OP_SLAB_UPD, OP_MUL_HI,
        OP_MUL_LO, OP_MSUM, OP_DIFF, OP_CELL_SET, OP_AXIS_ZERO, OP_INC_SET,
        OP_NEXT_SET, OP_EMIT_MISS, OP_EMIT_STEP
    } op_t;

    typedef enum logic [2:0] {
        DIV_T1, DIV_T2, DIV_CELL, DIV_INC, DIV_NEXT
    } div_sel_t;

    typedef struct packed {
        op_t      op;
        logic     div_start;
        div_sel_t div_sel;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic       in_box;
        logic [2:0] d_zero;
        logic       miss;
        logic       out_free;
        logic       last_now;
        logic       div_done;
    } status_t;

endpackage

`default_nettype wire

/* hdl/rgv_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module rgv_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rgv_pkg::DVD_W-1:0]   dividend,
    input  logic [rgv_pkg::DVS_W-1:0]   divisor,
    output logic                        done,
    output logic [rgv_pkg::DVD_W-1:0]   quotient
);
    import rgv_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;

    assign shifted  = {rem_reg, quo_reg[DVD_W-1]};
    assign trial    = shifted - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(DVD_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            if (!trial[DVS_W]) begin
                rem_reg <= trial[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/rgv_dp.sv */
// traversal datapath: slab test, setup arithmetic, dda stepping, result register
`default_nettype none

module rgv_dp (
    input  logic             aclk,
    input  logic             aresetn,
    input  rgv_pkg::cfg_t    cfg,
    input  rgv_pkg::cmd_t    cmd,
    output rgv_pkg::status_t st,
    input  logic [31:0]      s_origin_x,
    input  logic [31:0]      s_origin_y,
    input  logic [31:0]      s_origin_z,
    input  logic [31:0]      s_direction_x,
    input  logic [31:0]      s_direction_y,
    input  logic [31:0]      s_direction_z,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [3:0]       m_cell_x,
    output logic [3:0]       m_cell_y,
    output logic [3:0]       m_cell_z,
    output logic             m_hit,
    output logic             m_last
);
    import rgv_pkg::*;

    logic signed [31:0]     o_reg    [3];
    logic signed [31:0]     d_reg    [3];
    logic signed [MX_W-1:0] mx_reg   [3];
    logic signed [T_W-1:0]  tn_reg;
    logic signed [T_W-1:0]  tf_reg;
    logic signed [T_W-1:0]  t1_reg;
    logic                   miss_reg;
    logic                   tneg_reg;
    logic [PROD_W-1:0]      mhi_reg;
    logic [PROD_W-1:0]      mlo_reg;
    logic signed [SM_W-1:0] sm_reg;
    logic signed [DF_W-1:0] diff_reg;
    logic signed [5:0]      cell_reg [3];
    logic signed [5:0]      exit_reg [3];
    logic signed [1:0]      step_reg [3];
    logic [T_W-1:0]         inc_reg  [3];
    logic signed [T_W-1:0]  next_reg [3];
    logic                   m_valid_reg;
    logic [3:0]             cx_reg, cy_reg, cz_reg;
    logic                   hit_reg, last_reg;

    logic [1:0]              a;
    logic signed [31:0]      gmin_a, o_a, d_a;
    logic [31:0]             dmag_a;
    logic [4:0]              n_a;
    logic [4:0]              c5;
    logic [35:0]             csize;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        numag;
    logic                    t_neg;
    logic [DVD_W-1:0]        dividend;
    logic [DVS_W-1:0]        divisor;
    logic                    div_done;
    logic [DVD_W-1:0]        q;
    logic signed [T_W-1:0]   tq;
    logic [4:0]              cq;
    logic signed [MX_W-1:0]  mx_load [3];
    logic [2:0]              in_slab;
    logic [T_W-1:0]          tm;
    logic [23:0]             mop;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W:0]         msum;
    logic [LIM_W-1:0]        mclip;
    logic signed [SM_W-1:0]  sm_new;
    logic signed [DF_W-1:0]  entry;
    logic signed [T_W-1:0]   t_lo, t_hi;
    logic                    has;
    logic [1:0]              sel;
    logic signed [5:0]       newcell;
    logic signed [TS_W-1:0]  tsum;
    logic signed [T_W-1:0]   nnext;

    assign a      = cmd.axis;
    assign gmin_a = signed'(cfg.gmin[a]);
    assign o_a    = o_reg[a];
    assign d_a    = d_reg[a];
    assign dmag_a = d_a[31] ? 32'(-d_a) : 32'(d_a);
    assign n_a    = cfg.cells[a];
    assign c5     = {1'b0, cell_reg[a][3:0]} + {4'b0, ~d_a[31]};
    assign csize  = c5 * cfg.size;

    // grid upper corner and slab membership
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mx_load[k] = MX_W'(signed'(cfg.gmin[k]))
                       + MX_W'(signed'({1'b0, 36'(cfg.cells[k] * cfg.size)}));
            in_slab[k] = !(o_reg[k] < signed'(cfg.gmin[k]) || o_reg[k] > mx_reg[k]);
        end
    end

    // divider operands
    always_comb begin
        unique case (cmd.div_sel)
            DIV_T1:   num = NUM_W'(gmin_a) - NUM_W'(o_a);
            DIV_T2:   num = NUM_W'(mx_reg[a]) - NUM_W'(o_a);
            DIV_INC:  num = NUM_W'(signed'({1'b0, cfg.size}));
            DIV_NEXT: num = NUM_W'(signed'({1'b0, csize})) + NUM_W'(gmin_a) - NUM_W'(o_a);
            default:  num = '0;
        endcase
        numag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        t_neg = (cmd.div_sel != DIV_INC) && (num[NUM_W-1] != d_a[31]);
        if (cmd.div_sel == DIV_CELL) begin
            dividend = diff_reg[DF_W-1] ? '0 : DVD_W'(diff_reg);
            divisor  = {1'b0, cfg.size};
        end else begin
            dividend = {numag, {T_FRAC{1'b0}}};
            divisor  = dmag_a;
        end
    end

    rgv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (q)
    );

    // saturated t and clamped cell index from the quotient
    always_comb begin
        if (q[DVD_W-1:T_W-1] != '0) begin
            tq = tneg_reg ? T_MINV : T_MAXV;
        end else begin
            tq = tneg_reg ? -signed'(q[T_W-1:0]) : signed'(q[T_W-1:0]);
        end
        if (q[DVD_W-1:5] != '0 || q[4:0] >= n_a) begin
            cq = n_a - 5'd1;
        end else begin
            cq = q[4:0];
        end
        t_lo = (t1_reg > tq) ? tq : t1_reg;
        t_hi = (t1_reg > tq) ? t1_reg : tq;
    end

    // entry point: tn times direction, split in two 24 x 32 products
    always_comb begin
        tm     = tn_reg[T_W-1] ? T_W'(-tn_reg) : T_W'(tn_reg);
        mop    = (cmd.op == OP_MUL_HI) ? tm[T_W-1:T_FRAC] : tm[T_FRAC-1:0];
        prod   = mop * dmag_a;
        msum   = {1'b0, mhi_reg} + {1'b0, (mlo_reg >> T_FRAC)};
        mclip  = (msum > (PROD_W+1)'(PROD_LIMIT)) ? PROD_LIMIT : msum[LIM_W-1:0];
        sm_new = (tn_reg[T_W-1] ^ d_a[31]) ? -signed'({1'b0, mclip})
                                           : signed'({1'b0, mclip});
        entry  = st.in_box ? DF_W'(o_a) : DF_W'(o_a) + DF_W'(sm_reg);
    end

    // axis with the least next-boundary t, lower axis wins a tie
    always_comb begin
        has = 1'b0;
        sel = 2'd0;
        for (int k = 0; k < 3; k++) begin
            if (step_reg[k] != 2'sd0 && (!has || next_reg[k] < next_reg[sel])) begin
                sel = 2'(k);
                has = 1'b1;
            end
        end
        newcell = cell_reg[sel] + 6'(step_reg[sel]);
        tsum    = TS_W'(next_reg[sel]) + signed'({1'b0, inc_reg[sel]});
        nnext   = (tsum > TS_W'(T_MAXV)) ? T_MAXV : tsum[T_W-1:0];
    end

    always_comb begin
        st.in_box   = &in_slab;
        for (int k = 0; k < 3; k++) begin
            st.d_zero[k] = (d_reg[k] == 32'sd0);
        end
        st.miss     = miss_reg || (tn_reg > tf_reg) || (tf_reg < 0);
        st.out_free = !m_valid_reg || m_ready;
        st.last_now = !has || (newcell == exit_reg[sel]);
        st.div_done = div_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            miss_reg <= 1'b0;
        end else if (cmd.op == OP_LOAD) begin
            miss_reg <= 1'b0;
        end else if (cmd.op == OP_SLAB_ZERO && !in_slab[a]) begin
            miss_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            tneg_reg <= t_neg;
        end
        unique case (cmd.op)
            OP_LOAD: begin
                o_reg[0] <= signed'(s_origin_x);
                o_reg[1] <= signed'(s_origin_y);
                o_reg[2] <= signed'(s_origin_z);
                d_reg[0] <= signed'(s_direction_x);
                d_reg[1] <= signed'(s_direction_y);
                d_reg[2] <= signed'(s_direction_z);
                for (int k = 0; k < 3; k++) begin
                    mx_reg[k] <= mx_load[k];
                end
                tn_reg <= T_MINV;
                tf_reg <= T_MAXV;
            end
            OP_T1_SAVE: t1_reg <= tq;
            OP_SLAB_UPD: begin
                if (t_lo > tn_reg) tn_reg <= t_lo;
                if (t_hi < tf_reg) tf_reg <= t_hi;
            end
            OP_MUL_HI:   mhi_reg <= prod;
            OP_MUL_LO:   mlo_reg <= prod;
            OP_MSUM:     sm_reg  <= sm_new;
            OP_DIFF:     diff_reg <= entry - DF_W'(gmin_a);
            OP_CELL_SET: cell_reg[a] <= signed'({1'b0, cq});
            OP_AXIS_ZERO: begin
                step_reg[a] <= 2'sd0;
                exit_reg[a] <= 6'sd0;
                inc_reg[a]  <= '0;
                next_reg[a] <= T_MAXV;
            end
            OP_INC_SET: begin
                inc_reg[a]  <= unsigned'(tq);
                step_reg[a] <= d_a[31] ? -2'sd1 : 2'sd1;
                exit_reg[a] <= d_a[31] ? -6'sd1 : signed'({1'b0, n_a});
            end
            OP_NEXT_SET: next_reg[a] <= tq;
            OP_EMIT_STEP: begin
                if (!st.last_now) begin
                    cell_reg[sel] <= newcell;
                    next_reg[sel] <= nnext;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT_MISS || cmd.op == OP_EMIT_STEP) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT_MISS) begin
            cx_reg   <= 4'd0;
            cy_reg   <= 4'd0;
            cz_reg   <= 4'd0;
            hit_reg  <= 1'b0;
            last_reg <= 1'b1;
        end else if (cmd.op == OP_EMIT_STEP) begin
            cx_reg   <= cell_reg[0][3:0];
            cy_reg   <= cell_reg[1][3:0];
            cz_reg   <= cell_reg[2][3:0];
            hit_reg  <= 1'b1;
            last_reg <= st.last_now;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_cell_x = cx_reg;
    assign m_cell_y = cy_reg;
    assign m_cell_z = cz_reg;
    assign m_hit    = hit_reg;
    assign m_last   = last_reg;

endmodule

`default_nettype wire

/* hdl/rgv_ctrl.sv */
// traversal sequencer
`default_nettype none

module rgv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rgv_pkg::status_t st,
    output rgv_pkg::cmd_t    cmd
);
    import rgv_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       last_axis;
    state_t     axis_start;

    assign last_axis  = (axis_reg == AXIS_LAST);
    assign axis_start = st.in_box ? ST_DIFF : ST_MHI;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_T1;
        cmd.axis      = axis_reg;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    axis_next  = 2'd0;
                    state_next = ST_SLAB;
                end
            end
            ST_SLAB: begin
                priority if (st.in_box) begin
                    axis_next  = 2'd0;
                    state_next = ST_DIFF;
                end else if (st.d_zero[axis_reg]) begin
                    cmd.op = OP_SLAB_ZERO;
                    if (last_axis) state_next = ST_HITCHK;
                    else axis_next = axis_reg + 2'd1;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_T1;
                    state_next    = ST_T1W;
                end
            end
            ST_T1W: begin
                cmd.div_sel = DIV_T2;
                if (st.div_done) begin
                    cmd.op        = OP_T1_SAVE;
                    cmd.div_start = 1'b1;
                    state_next    = ST_T2W;
                end
            end
            ST_T2W: begin
                if (st.div_done) begin
                    cmd.op = OP_SLAB_UPD;
                    if (last_axis) begin
                        state_next = ST_HITCHK;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_SLAB;
                    end
                end
            end
            ST_HITCHK: begin
                axis_next  = 2'd0;
                state_next = st.miss ? ST_MISS : ST_MHI;
            end
            ST_MISS: begin
                if (st.out_free) begin
                    cmd.op     = OP_EMIT_MISS;
                    state_next = ST_IDLE;
                end
            end
            ST_MHI: begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_MLO;
            end
            ST_MLO: begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_MSUM;
            end
            ST_MSUM: begin
                cmd.op     = OP_MSUM;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_CELL;
                state_next    = ST_CELLW;
            end
            ST_CELLW: begin
                cmd.div_sel = DIV_CELL;
                if (st.div_done) begin
                    cmd.op     = OP_CELL_SET;
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS: begin
                if (st.d_zero[axis_reg]) begin
                    cmd.op = OP_AXIS_ZERO;
                    if (last_axis) begin
                        state_next = ST_EMIT;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = axis_start;
                    end
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_INC;
                    state_next    = ST_INCW;
                end
            end
            ST_INCW: begin
                cmd.div_sel = DIV_NEXT;
                if (st.div_done) begin
                    cmd.op        = OP_INC_SET;
                    cmd.div_start = 1'b1;
                    state_next    = ST_NEXTW;
                end
            end
            ST_NEXTW: begin
                if (st.div_done) begin
                    cmd.op = OP_NEXT_SET;
                    if (last_axis) begin
                        state_next = ST_EMIT;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = axis_start;
                    end
                end
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.op = OP_EMIT_STEP;
                    if (st.last_now) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/ray_grid_voxel_traversal.sv */
// top level of the ray voxel traversal block: register file, sequencer and datapath
//
// channel   direction  handshake          contents
// s_*       in         s_valid/s_ready    ray origin and direction, q16.16
// m_*       out        m_valid/m_ready    one visited cell, hit and last flags
// apb       in/out     psel/penable       grid corner, cell size, cell counts
//
// one ray at a time; a request is taken only while the sequencer is idle
// slab test: up to 6 divisions, setup: 3 per axis, each in the
// shared one-bit-per-cycle divider; after the first cell of a hit,
// one cell per cycle while m_ready is high
// a pending result in the output register does not hold off the next request
// reset is synchronous and active low; registers return to their reset values

`default_nettype none

module ray_grid_voxel_traversal (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_origin_x,
    input  logic [31:0] s_origin_y,
    input  logic [31:0] s_origin_z,
    input  logic [31:0] s_direction_x,
    input  logic [31:0] s_direction_y,
    input  logic [31:0] s_direction_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_cell_x,
    output logic [3:0]  m_cell_y,
    output logic [3:0]  m_cell_z,
    output logic        m_hit,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rgv_pkg::*;

    // register map, one word each
    localparam logic [2:0] REG_GMIN_X    = 3'd0;
    localparam logic [2:0] REG_GMIN_Y    = 3'd1;
    localparam logic [2:0] REG_GMIN_Z    = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE = 3'd3;
    localparam logic [2:0] REG_CELLS_X   = 3'd4;
    localparam logic [2:0] REG_CELLS_Y   = 3'd5;
    localparam logic [2:0] REG_CELLS_Z   = 3'd6;

    localparam logic [30:0] SIZE_RESET  = 31'(1) << COORD_FRAC;
    localparam logic [4:0]  CELLS_RESET = 5'(MAX_CELLS);

    logic [31:0] gmin_reg  [3];
    logic [30:0] size_reg;
    logic [4:0]  cells_reg [3];
    logic        wr_en;
    logic [2:0]  reg_idx;
    cfg_t        cfg;
    cmd_t        cmd;
    status_t     st;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                gmin_reg[k]  <= '0;
                cells_reg[k] <= CELLS_RESET;
            end
            size_reg <= SIZE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GMIN_X:    gmin_reg[0]  <= pwdata;
                REG_GMIN_Y:    gmin_reg[1]  <= pwdata;
                REG_GMIN_Z:    gmin_reg[2]  <= pwdata;
                REG_CELL_SIZE: size_reg     <= pwdata[30:0];
                REG_CELLS_X:   cells_reg[0] <= pwdata[4:0];
                REG_CELLS_Y:   cells_reg[1] <= pwdata[4:0];
                REG_CELLS_Z:   cells_reg[2] <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GMIN_X:    prdata = gmin_reg[0];
            REG_GMIN_Y:    prdata = gmin_reg[1];
            REG_GMIN_Z:    prdata = gmin_reg[2];
            REG_CELL_SIZE: prdata = {1'b0, size_reg};
            REG_CELLS_X:   prdata = {27'd0, cells_reg[0]};
            REG_CELLS_Y:   prdata = {27'd0, cells_reg[1]};
            REG_CELLS_Z:   prdata = {27'd0, cells_reg[2]};
            default:       prdata = '0;
        endcase
    end

    // effective values: zero size acts as one, counts clamp to 1..max
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cfg.gmin[k] = gmin_reg[k];
            if (cells_reg[k] == 5'd0) begin
                cfg.cells[k] = 5'd1;
            end else if (cells_reg[k] > CELLS_RESET) begin
                cfg.cells[k] = CELLS_RESET;
            end else begin
                cfg.cells[k] = cells_reg[k];
            end
        end
        cfg.size = (size_reg == '0) ? 31'd1 : size_reg;
    end

    rgv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rgv_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .st            (st),
        .s_origin_x    (s_origin_x),
        .s_origin_y    (s_origin_y),
        .s_origin_z    (s_origin_z),
        .s_direction_x (s_direction_x),
        .s_direction_y (s_direction_y),
        .s_direction_z (s_direction_z),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_cell_x      (m_cell_x),
        .m_cell_y      (m_cell_y),
        .m_cell_z      (m_cell_z),
        .m_hit         (m_hit),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

/* hdl/rgv_chk.sv */
// port-level checks for the voxel traversal block, bound to the top level
`default_nettype none

module rgv_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_cell_x,
    input logic [3:0] m_cell_y,
    input logic [3:0] m_cell_z,
    input logic       m_hit,
    input logic       m_last,
    input logic       pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_x) && $stable(m_cell_y)
            && $stable(m_cell_z) && $stable(m_hit) && $stable(m_last))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while a ray is in flight");

    a_miss_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_last)
        else $error("miss result not marked last");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_cell_x == 4'd0 && m_cell_y == 4'd0 && m_cell_z == 4'd0)
        else $error("miss result carries a cell index");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("register port stalled");

endmodule

bind ray_grid_voxel_traversal rgv_chk u_rgv_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_cell_x (m_cell_x),
    .m_cell_y (m_cell_y),
    .m_cell_z (m_cell_z),
    .m_hit    (m_hit),
    .m_last   (m_last),
    .pready   (pready)
);

`default_nettype wire

/* tb/ray_grid_voxel_traversal_tb.sv */
// self-checking testbench for the ray voxel traversal block
`timescale 1ns / 100ps

module ray_grid_voxel_traversal_tb;
    import rgv_pkg::*;

    // register map, one word per register
    typedef enum int {
        REG_GMIN_X = 0, REG_GMIN_Y, REG_GMIN_Z, REG_CELL_SIZE,
        REG_CELLS_X, REG_CELLS_Y, REG_CELLS_Z
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
    } ray_t;

    typedef struct {
        logic [3:0] cx, cy, cz;
        logic       hit, last;
    } cell_res_t;

    localparam longint TQ_MAX  = (64'sd1 <<< (T_W - 1)) - 1;
    localparam longint TQ_MIN  = -TQ_MAX - 1;
    localparam longint MUL_LIM = 64'sd1 <<< 40;
    localparam int     RUN_MAX = 3 * (MAX_CELLS - 1) + 1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    logic [31:0] s_direction_x = '0, s_direction_y = '0, s_direction_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_cell_x, m_cell_y, m_cell_z;
    logic        m_hit, m_last;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ray_grid_voxel_traversal dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_direction_x(s_direction_x), .s_direction_y(s_direction_y),
        .s_direction_z(s_direction_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cell_x(m_cell_x), .m_cell_y(m_cell_y), .m_cell_z(m_cell_z),
        .m_hit(m_hit), .m_last(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of the register file
    longint    grid_lo[3];
    longint    edge_len;
    int        axis_cells[3];

    cell_res_t expected_cells[$];
    int        mismatches = 0;
    int        rays_sent = 0;
    int        misses_sent = 0;
    int        cells_seen = 0;
    int        send_gap_pct = 0;
    int        recv_gap_pct = 0;

    initial forever #5 aclk = ~aclk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) m_ready <= ($urandom_range(0, 99) >= recv_gap_pct);

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // result checker: every accepted cell against the oldest expectation
    always @(posedge aclk) begin
        cell_res_t e;
        if (aresetn && m_valid && m_ready) begin
            cells_seen++;
            if (expected_cells.size() == 0) begin
                report_mismatch($sformatf("unexpected cell %0d,%0d,%0d",
                                          m_cell_x, m_cell_y, m_cell_z));
            end else begin
                e = expected_cells.pop_front();
                if (m_cell_x !== e.cx || m_cell_y !== e.cy || m_cell_z !== e.cz)
                    report_mismatch($sformatf("cell %0d,%0d,%0d expected %0d,%0d,%0d",
                        m_cell_x, m_cell_y, m_cell_z, e.cx, e.cy, e.cz));
                if (m_hit !== e.hit)
                    report_mismatch($sformatf("hit %b expected %b", m_hit, e.hit));
                if (m_last !== e.last)
                    report_mismatch($sformatf("last %b expected %b", m_last, e.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // traversal predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // (num << frac) / den, truncated toward zero and saturated
    function automatic longint t_quot(longint num, longint den);
        longint unsigned nm, dm, q;
        bit neg;
        nm  = magnitude(num);
        dm  = magnitude(den);
        neg = (num < 0) != (den < 0);
        if (dm == 0) return TQ_MAX;
        q = (nm << T_FRAC) / dm;
        if (neg) return (q > longint'(TQ_MAX)) ? TQ_MIN : -longint'(q);
        return (q > longint'(TQ_MAX)) ? TQ_MAX : longint'(q);
    endfunction

    // t * direction, back in coordinate units, magnitude limited
    function automatic longint t_times_dir(longint t, longint d);
        longint unsigned tm, dm, hi, lo, m;
        bit neg;
        tm  = magnitude(t);
        dm  = magnitude(d);
        neg = (t < 0) != (d < 0);
        hi  = tm >> T_FRAC;
        lo  = tm & ((64'd1 << T_FRAC) - 1);
        if (dm != 0 && hi > longint'(MUL_LIM) / dm) m = MUL_LIM;
        else m = hi * dm + ((lo * dm) >> T_FRAC);
        if (m > longint'(MUL_LIM)) m = MUL_LIM;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint used_edge();
        return (edge_len == 0) ? 1 : edge_len;
    endfunction

    function automatic int used_cells(int a);
        if (axis_cells[a] == 0) return 1;
        if (axis_cells[a] > MAX_CELLS) return MAX_CELLS;
        return axis_cells[a];
    endfunction

    function automatic int start_cell(longint coord, int a);
        longint diff, q;
        diff = coord - grid_lo[a];
        if (diff < 0) return 0;
        q = diff / used_edge();
        return (q >= used_cells(a)) ? used_cells(a) - 1 : int'(q);
    endfunction

    function automatic void predict_cells(ray_t r);
        longint    o[3], d[3], hi_edge[3], tinc[3], tnext[3];
        longint    sz, tn, tf, t1, t2, tt, ent;
        int        cp[3], sgn[3], ex[3];
        int        sel, count;
        bit        in_box, hit;
        cell_res_t c;
        cell_res_t run[$];
        sz = used_edge();
        tn = TQ_MIN;
        tf = TQ_MAX;
        in_box = 1;
        hit = 1;
        for (int a = 0; a < 3; a++) begin
            o[a] = longint'($signed(r.org[a]));
            d[a] = longint'($signed(r.dir[a]));
            hi_edge[a] = grid_lo[a] + sz * used_cells(a);
            if (o[a] < grid_lo[a] || o[a] > hi_edge[a]) in_box = 0;
        end
        // slab test, only needed when the origin lies outside the box
        if (!in_box) begin
            for (int a = 0; a < 3; a++) begin
                if (d[a] == 0) begin
                    if (o[a] < grid_lo[a] || o[a] > hi_edge[a]) hit = 0;
                end else begin
                    t1 = t_quot(grid_lo[a] - o[a], d[a]);
                    t2 = t_quot(hi_edge[a] - o[a], d[a]);
                    if (t1 > t2) begin
                        tt = t1; t1 = t2; t2 = tt;
                    end
                    if (t1 > tn) tn = t1;
                    if (t2 < tf) tf = t2;
                    if (tn > tf || tf < 0) hit = 0;
                end
            end
        end
        if (!hit) begin
            c = '{cx: 0, cy: 0, cz: 0, hit: 1'b0, last: 1'b1};
            expected_cells.push_back(c);
            misses_sent++;
            return;
        end
        // per-axis setup
        for (int a = 0; a < 3; a++) begin
            ent = in_box ? o[a] : o[a] + t_times_dir(tn, d[a]);
            cp[a] = start_cell(ent, a);
            if (d[a] < 0) begin
                sgn[a]   = -1;
                ex[a]    = -1;
                tinc[a]  = t_quot(sz, -d[a]);
                tnext[a] = t_quot(cp[a] * sz + grid_lo[a] - o[a], d[a]);
            end else if (d[a] > 0) begin
                sgn[a]   = 1;
                ex[a]    = used_cells(a);
                tinc[a]  = t_quot(sz, d[a]);
                tnext[a] = t_quot((cp[a] + 1) * sz + grid_lo[a] - o[a], d[a]);
            end else begin
                sgn[a]   = 0;
                ex[a]    = 0;
                tinc[a]  = 0;
                tnext[a] = TQ_MAX;
            end
        end
        c = '{cx: 4'(cp[0]), cy: 4'(cp[1]), cz: 4'(cp[2]), hit: 1'b1, last: 1'b0};
        run.push_back(c);
        count = 1;
        // dda walk: least next-boundary t steps, lower axis wins a tie
        while (count < RUN_MAX) begin
            sel = -1;
            for (int k = 0; k < 3; k++)
                if (sgn[k] != 0 && (sel < 0 || tnext[k] < tnext[sel])) sel = k;
            if (sel < 0) break;
            cp[sel] += sgn[sel];
            if (tnext[sel] > TQ_MAX - tinc[sel]) tnext[sel] = TQ_MAX;
            else tnext[sel] += tinc[sel];
            if (cp[sel] == ex[sel]) break;
            c = '{cx: 4'(cp[0]), cy: 4'(cp[1]), cz: 4'(cp[2]), hit: 1'b1, last: 1'b0};
            run.push_back(c);
            count++;
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[i]) expected_cells.push_back(run[i]);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_GMIN_X, REG_GMIN_Y, REG_GMIN_Z:
                grid_lo[int'(idx)] = longint'($signed(value));
            REG_CELL_SIZE: edge_len = longint'(value[30:0]);
            default: axis_cells[int'(idx) - int'(REG_CELLS_X)] = int'(value[4:0]);
        endcase
    endtask

    task automatic load_grid(input logic [31:0] gx, gy, gz, sz,
                             input logic [31:0] nx, ny, nz);
        write_reg(REG_GMIN_X, gx);
        write_reg(REG_GMIN_Y, gy);
        write_reg(REG_GMIN_Z, gz);
        write_reg(REG_CELL_SIZE, sz);
        write_reg(REG_CELLS_X, nx);
        write_reg(REG_CELLS_Y, ny);
        write_reg(REG_CELLS_Z, nz);
    endtask

    // one ray request; the expectation is built at the accepting edge
    task automatic send_ray(input ray_t r);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_origin_x    <= r.org[0];
        s_origin_y    <= r.org[1];
        s_origin_z    <= r.org[2];
        s_direction_x <= r.dir[0];
        s_direction_y <= r.dir[1];
        s_direction_z <= r.dir[2];
        do @(posedge aclk); while (!s_ready);
        predict_cells(r);
        rays_sent++;
    endtask

    // sender holds off until every expected cell is back
    task automatic drain_all();
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic ray_t mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
        ray_t r;
        r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
        r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
        return r;
    endfunction

    // mostly rays aimed at a point in the box, some from inside, some noise
    function automatic ray_t random_ray();
        ray_t   r;
        longint span, lim, tgt, org;
        int     kind, shift;
        kind = $urandom_range(0, 99);
        shift = $urandom_range(0, 4);
        for (int a = 0; a < 3; a++) begin
            span = used_edge() * used_cells(a);
            lim  = (span > (64'sd1 << 29)) ? (64'sd1 << 29) : span;
            tgt  = grid_lo[a] + longint'({$urandom, $urandom} % longint'(span + 1));
            if (kind < 15) begin
                r.org[a] = $urandom;
                r.dir[a] = $urandom;
            end else if (kind < 28) begin
                r.org[a] = tgt[31:0];
                r.dir[a] = ($urandom_range(0, 5) == 0) ? 32'd0
                         : 32'($signed($urandom) >>> $urandom_range(8, 20));
            end else begin
                org = tgt + longint'($urandom_range(0, 32'(4 * lim))) - 2 * lim;
                r.org[a] = org[31:0];
                r.dir[a] = ($urandom_range(0, 7) == 0) ? 32'd0
                         : 32'((tgt - org) >>> shift);
            end
        end
        return r;
    endfunction

    task automatic random_rays(input int n);
        repeat (n) send_ray(random_ray());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // axis rays from inside the box, each sign, including an exact tie
        send_ray(mk_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 0, 0));
        send_ray(mk_ray(32'h0008_8000, 32'h000F_8000, 32'h0003_0000, 0, 32'hFFFF_0000, 0));
        send_ray(mk_ray(32'h0002_0000, 32'h0004_0000, 32'h0000_0000, 0, 0, 32'h0000_4000));
        send_ray(mk_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_ray(mk_ray(32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
                        32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
        // zero direction: start cell only when in the box, a miss when outside
        send_ray(mk_ray(32'h0005_4000, 32'h000A_0000, 32'h0010_0000, 0, 0, 0));
        send_ray(mk_ray(32'hFFFF_0000, 32'h0005_0000, 32'h0005_0000, 0, 0, 0));
        // zero direction axis outside its slab misses
        send_ray(mk_ray(32'h0005_0000, 32'h0020_0000, 32'h0005_0000, 32'h0001_0000, 0, 0));
        // pointing away from the box
        send_ray(mk_ray(32'hFFF0_0000, 32'h0002_0000, 32'h0002_0000, 32'hFFFF_0000, 0, 0));
        // entering from below on every axis, start index clamp from a negative entry
        send_ray(mk_ray(32'hFFFE_0000, 32'hFFFC_0000, 32'hFFFF_8000,
                        32'h0001_0000, 32'h0002_0000, 32'h0000_8000));
        send_ray(mk_ray(32'h0018_0000, 32'h0008_0000, 32'h0008_0000,
                        32'hFFFF_0000, 32'h0000_0100, 32'hFFFF_FF00));
        // field extremes
        send_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_ray(mk_ray(32'h0008_0000, 32'h0008_0000, 32'h0008_0000,
                        32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_ray(mk_ray(32'hFFFF_FFFF, 32'h0000_0001, 32'h0008_0000,
                        32'h0000_0001, 32'h0000_0001, 32'h8000_0000));
        // longest walk, corner to corner with slightly uneven slopes
        send_ray(mk_ray(32'h0000_0100, 32'h0000_0200, 32'h0000_0300,
                        32'h0001_0000, 32'h0000_FF00, 32'h0000_FE00));
        drain_all();
    endtask

    task automatic test_default_grid();
        random_rays(150);
        drain_all();
    endtask

    task automatic test_offset_grid();
        load_grid(32'hFFF8_0000, 32'h0003_4000, 32'hFFFF_C000, 32'h0000_4000,
                  32'd3, 32'd16, 32'd1);
        random_rays(120);
        drain_all();
    endtask

    task automatic test_extreme_grid();
        load_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
                  32'd1, 32'd16, 32'd2);
        random_rays(40);
        drain_all();
        // top bit of cell_size ignored, counts beyond range and a zero size
        load_grid(32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000,
                  32'd0, 32'd31, 32'd17);
        send_ray(mk_ray(0, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0001, 32'h0000_0001, 0));
        random_rays(40);
        drain_all();
        load_grid(32'h0001_0000, 32'h0000_2000, 32'hFFFE_0000, 32'h0002_0000,
                  32'd16, 32'd4, 32'd9);
        random_rays(60);
        drain_all();
    endtask

    // run sequence and end of test
    initial begin
        edge_len   = 64'sd1 <<< COORD_FRAC;
        foreach (grid_lo[a]) begin
            grid_lo[a]    = 0;
            axis_cells[a] = MAX_CELLS;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_gap_pct = 28;
        recv_gap_pct = 57;
        test_directed();
        test_default_grid();

        send_gap_pct = 57;
        recv_gap_pct = 28;
        test_offset_grid();

        // back-to-back with no idling at all
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_extreme_grid();

        $display("%0d rays sent (%0d expected to miss), %0d cells checked",
                 rays_sent, misses_sent, cells_seen);
        $display("grids covered: reset, offset small cells, extreme corners and sizes");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("timeout with %0d cells outstanding", expected_cells.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
